FILE: sv/gtg_pkg.sv
// Shared constants, types and the arctangent table of the go-to-goal controller.
// No dependencies; every other file imports this package.
`default_nettype none

package gtg_pkg;

    // Vectoring CORDIC depth, from 8 to 24.
    localparam int CORDIC_STAGES = 16;

    // Square root: one result bit per stage.
    localparam int ROOT_W = 17;
    localparam int SQ_W   = 34;

    // CORDIC datapath: error scaled by 2^8 plus growth, angle in Q3.20.
    localparam int CW = 28;
    localparam int ZW = 24;

    localparam int ITER_STAGES = (CORDIC_STAGES > ROOT_W) ? CORDIC_STAGES : ROOT_W;

    // Registers from the accepting edge to the result strobe.
    localparam int LATENCY = ITER_STAGES + 6;

    localparam logic signed [ZW-1:0] ANG_HALF_PI = 24'sd1647099;
    localparam logic signed [15:0]   BEARING_MAX = 16'sd12868;
    localparam logic signed [15:0]   BEARING_MIN = -16'sd12868;

    localparam int CFG_W = 16;

    typedef enum logic [1:0] {
        REG_GOAL_X,
        REG_GOAL_Y,
        REG_LINEAR_GAIN,
        REG_ANGULAR_GAIN
    } cfg_reg_t;

    // One beat as it travels through the iterative stages.
    typedef struct packed {
        logic [SQ_W-1:0]          rem;
        logic [ROOT_W-1:0]        root;
        logic signed [CW-1:0]     x;
        logic signed [CW-1:0]     y;
        logic signed [ZW-1:0]     z;
        logic                     zero;
        logic signed [14:0]       heading;
    } gtg_lane_t;

    // Rounded arctangent of 2^-i in Q3.20.
    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        case (i)
            0:       return 24'sd823550;
            1:       return 24'sd486170;
            2:       return 24'sd256879;
            3:       return 24'sd130396;
            4:       return 24'sd65451;
            5:       return 24'sd32757;
            6:       return 24'sd16383;
            7:       return 24'sd8192;
            8:       return 24'sd4096;
            9:       return 24'sd2048;
            10:      return 24'sd1024;
            11:      return 24'sd512;
            12:      return 24'sd256;
            13:      return 24'sd128;
            14:      return 24'sd64;
            15:      return 24'sd32;
            16:      return 24'sd16;
            17:      return 24'sd8;
            18:      return 24'sd4;
            19:      return 24'sd2;
            20:      return 24'sd1;
            default: return 24'sd0;
        endcase
    endfunction

endpackage

`default_nettype wire

FILE: sv/gtg_front.sv
// Front end: position error, squares, sum and CORDIC pre-rotation (three stages).
// Depends on gtg_pkg.
`default_nettype none

module gtg_front
    import gtg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic signed [15:0] pose_x,
    input  wire logic signed [15:0] pose_y,
    input  wire logic signed [14:0] pose_heading,
    input  wire logic signed [15:0] goal_x,
    input  wire logic signed [15:0] goal_y,
    output gtg_lane_t               lane_out,
    output logic                    lane_valid
);

    // Stage 1: error
    logic signed [16:0] ex_reg, ey_reg, ex_next, ey_next;
    logic signed [14:0] head1_reg;
    logic               v1_reg;

    // Stage 2: squares and pre-rotated vector
    logic [SQ_W-1:0]      sqx_reg, sqy_reg, sqx_next, sqy_next;
    logic signed [CW-1:0] x2_reg, y2_reg, x2_next, y2_next;
    logic signed [ZW-1:0] z2_reg, z2_next;
    logic                 zero2_reg, zero2_next;
    logic signed [14:0]   head2_reg;
    logic                 v2_reg;

    // Stage 3: sum of squares
    gtg_lane_t lane_reg, lane_next;
    logic      v3_reg;

    logic signed [33:0]   px, py;
    logic signed [CW-1:0] xs, ys;

    assign ex_next = $signed({goal_x[15], goal_x}) - $signed({pose_x[15], pose_x});
    assign ey_next = $signed({goal_y[15], goal_y}) - $signed({pose_y[15], pose_y});

    always_comb
    begin
        px = ex_reg * ex_reg;
        py = ey_reg * ey_reg;
        sqx_next = px[SQ_W-1:0];
        sqy_next = py[SQ_W-1:0];
        xs = $signed({{(CW-25){ex_reg[16]}}, ex_reg, 8'd0});
        ys = $signed({{(CW-25){ey_reg[16]}}, ey_reg, 8'd0});
        x2_next = xs;
        y2_next = ys;
        z2_next = '0;
        // Rotate a left half plane vector by a quarter turn
        if (xs < 0)
        begin
            if (ys >= 0)
            begin
                x2_next = ys;
                y2_next = -xs;
                z2_next = ANG_HALF_PI;
            end
            else
            begin
                x2_next = -ys;
                y2_next = xs;
                z2_next = -ANG_HALF_PI;
            end
        end
        zero2_next = (ex_reg == 17'sd0) && (ey_reg == 17'sd0);
    end

    always_comb
    begin
        lane_next.rem     = sqx_reg + sqy_reg;
        lane_next.root    = '0;
        lane_next.x       = x2_reg;
        lane_next.y       = y2_reg;
        lane_next.z       = z2_reg;
        lane_next.zero    = zero2_reg;
        lane_next.heading = head2_reg;
    end

    always_ff @(posedge clk)
    begin
        ex_reg    <= ex_next;
        ey_reg    <= ey_next;
        head1_reg <= pose_heading;
        sqx_reg   <= sqx_next;
        sqy_reg   <= sqy_next;
        x2_reg    <= x2_next;
        y2_reg    <= y2_next;
        z2_reg    <= z2_next;
        zero2_reg <= zero2_next;
        head2_reg <= head1_reg;
        lane_reg  <= lane_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign lane_out   = lane_reg;
    assign lane_valid = v3_reg;

endmodule

`default_nettype wire

FILE: sv/gtg_iter.sv
// Iterative core: a square root bit and/or a CORDIC vectoring step per stage.
// Depends on gtg_pkg.
`default_nettype none

module gtg_iter
    import gtg_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  gtg_lane_t      lane_in,
    input  wire logic      valid_in,
    output gtg_lane_t      lane_out,
    output logic           valid_out
);

    gtg_lane_t         src       [ITER_STAGES];
    gtg_lane_t         lane_next [ITER_STAGES];
    gtg_lane_t         lane_reg  [ITER_STAGES];
    logic [SQ_W:0]     trial     [ITER_STAGES];
    logic [ITER_STAGES-1:0] valid_reg;

    always_comb
    begin
        src[0] = lane_in;
        for (int s = 1; s < ITER_STAGES; s++)
        begin
            src[s] = lane_reg[s-1];
        end
        for (int s = 0; s < ITER_STAGES; s++)
        begin
            lane_next[s] = src[s];
            trial[s]     = '0;
            // Restoring square root: try the next lower root bit
            if (s < ROOT_W)
            begin
                trial[s] = ((SQ_W+1)'(src[s].root) << (ROOT_W - s))
                         + ((SQ_W+1)'(1) << (2 * (ROOT_W - 1 - s)));
                if ({1'b0, src[s].rem} >= trial[s])
                begin
                    lane_next[s].rem  = src[s].rem - trial[s][SQ_W-1:0];
                    lane_next[s].root = src[s].root | (ROOT_W'(1) << (ROOT_W - 1 - s));
                end
            end
            // Vectoring step: drive y toward zero
            if (s < CORDIC_STAGES)
            begin
                if ($signed(src[s].y) > 0)
                begin
                    lane_next[s].x = src[s].x + ($signed(src[s].y) >>> s);
                    lane_next[s].y = src[s].y - ($signed(src[s].x) >>> s);
                    lane_next[s].z = src[s].z + atan_entry(s);
                end
                else
                begin
                    lane_next[s].x = src[s].x - ($signed(src[s].y) >>> s);
                    lane_next[s].y = src[s].y + ($signed(src[s].x) >>> s);
                    lane_next[s].z = src[s].z - atan_entry(s);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < ITER_STAGES; s++)
        begin
            lane_reg[s] <= lane_next[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[ITER_STAGES-2:0], valid_in};
        end
    end

    assign lane_out  = lane_reg[ITER_STAGES-1];
    assign valid_out = valid_reg[ITER_STAGES-1];

endmodule

`default_nettype wire

FILE: sv/gtg_back.sv
// Back end: saturate distance, round and clamp bearing, apply gains (three stages).
// Depends on gtg_pkg.
`default_nettype none

module gtg_back
    import gtg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  gtg_lane_t               lane_in,
    input  wire logic               valid_in,
    input  wire logic [7:0]         linear_gain,
    input  wire logic [7:0]         angular_gain,
    output logic                    done,
    output logic [16:0]             linear_speed,
    output logic signed [17:0]      turn_rate,
    output logic [15:0]             distance,
    output logic signed [14:0]      bearing
);

    // Stage 1
    logic [15:0]        dist1_reg, dist1_next;
    logic signed [14:0] brg1_reg, brg1_next;
    logic signed [14:0] head1_reg;
    logic               v1_reg;

    // Stage 2
    logic [23:0]        sprod_reg, sprod_next;
    logic signed [24:0] tprod_reg, tprod_next;
    logic [15:0]        dist2_reg;
    logic signed [14:0] brg2_reg;
    logic               v2_reg;

    // Stage 3 (outputs)
    logic [16:0]        speed_reg, speed_next;
    logic signed [17:0] turn_reg, turn_next;
    logic [15:0]        dist3_reg;
    logic signed [14:0] brg3_reg;
    logic               done_reg;

    logic signed [ZW-1:0] zr;
    logic signed [15:0]   zs;
    logic signed [15:0]   herr;
    logic [24:0]          srnd;
    logic signed [25:0]   trnd;
    logic signed [21:0]   tsh;

    always_comb
    begin
        dist1_next = lane_in.root[ROOT_W-1] ? 16'hFFFF : lane_in.root[15:0];
        zr = lane_in.z + ZW'(128);
        zs = zr[ZW-1:8];
        if (lane_in.zero)
        begin
            brg1_next = '0;
        end
        else if (zs > BEARING_MAX)
        begin
            brg1_next = BEARING_MAX[14:0];
        end
        else if (zs < BEARING_MIN)
        begin
            brg1_next = BEARING_MIN[14:0];
        end
        else
        begin
            brg1_next = zs[14:0];
        end
    end

    always_comb
    begin
        herr       = $signed({brg1_reg[14], brg1_reg}) - $signed({head1_reg[14], head1_reg});
        sprod_next = dist1_reg * linear_gain;
        tprod_next = herr * $signed({1'b0, angular_gain});
    end

    always_comb
    begin
        srnd = {1'b0, sprod_reg} + 25'd8;
        speed_next = (srnd[24:4] > 21'd131071) ? 17'h1FFFF : srnd[20:4];
        trnd = $signed({tprod_reg[24], tprod_reg}) + 26'sd8;
        tsh  = trnd[25:4];
        if (tsh > 22'sd131071)
        begin
            turn_next = 18'sd131071;
        end
        else if (tsh < -22'sd131072)
        begin
            turn_next = -18'sd131072;
        end
        else
        begin
            turn_next = tsh[17:0];
        end
    end

    always_ff @(posedge clk)
    begin
        dist1_reg <= dist1_next;
        brg1_reg  <= brg1_next;
        head1_reg <= lane_in.heading;
        sprod_reg <= sprod_next;
        tprod_reg <= tprod_next;
        dist2_reg <= dist1_reg;
        brg2_reg  <= brg1_reg;
        speed_reg <= speed_next;
        turn_reg  <= turn_next;
        dist3_reg <= dist2_reg;
        brg3_reg  <= brg2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= valid_in;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    assign done         = done_reg;
    assign linear_speed = speed_reg;
    assign turn_rate    = turn_reg;
    assign distance     = dist3_reg;
    assign bearing      = brg3_reg;

endmodule

`default_nettype wire

FILE: sv/go_to_goal_p_controller_core.sv
// Top level of the go-to-goal proportional controller: configuration registers and
// the front, iterative and back pipeline sections. Depends on gtg_pkg and gtg_front,
// gtg_iter, gtg_back.
//
// Usage: a pose beat (pose_x, pose_y in Q5.10, pose_heading in Q2.12) is taken at
// every rising edge where start is high; busy stays low, so a new pose may be given
// in every cycle. Each pose yields exactly one drive command after the front,
// iterative and back sections, marked by done for one cycle: linear_speed (Q7.10),
// turn_rate (Q5.12), distance (Q6.10) and bearing (Q2.12). The latency is set by the
// iterative section, one stage per square root bit and per CORDIC step, whichever
// is deeper. The receiver cannot stall the block; results must be taken in the
// cycle done is high. Write goal and gains through cfg_write/cfg_index/cfg_data
// only while no pose is in flight.
`default_nettype none

module go_to_goal_p_controller_core
    import gtg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // command channel
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] pose_x,
    input  wire logic signed [15:0] pose_y,
    input  wire logic signed [14:0] pose_heading,
    // result channel
    output logic                    done,
    output logic [16:0]             linear_speed,
    output logic signed [17:0]      turn_rate,
    output logic [15:0]             distance,
    output logic signed [14:0]      bearing,
    // configuration write port
    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data
);

    logic signed [15:0] goal_x_reg;
    logic signed [15:0] goal_y_reg;
    logic [7:0]         lin_gain_reg;
    logic [7:0]         ang_gain_reg;

    gtg_lane_t front_lane, iter_lane;
    logic      front_valid, iter_valid;
    logic      accept;

    // Fully pipelined: never hold off a pose.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration registers: drop data bits above each register's width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg   <= '0;
            goal_y_reg   <= '0;
            lin_gain_reg <= 8'd32;
            ang_gain_reg <= 8'd64;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GOAL_X:       goal_x_reg   <= cfg_data[15:0];
                REG_GOAL_Y:       goal_y_reg   <= cfg_data[15:0];
                REG_LINEAR_GAIN:  lin_gain_reg <= cfg_data[7:0];
                REG_ANGULAR_GAIN: ang_gain_reg <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // Error, squares, pre-rotation.
    gtg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (accept),
        .pose_x       (pose_x),
        .pose_y       (pose_y),
        .pose_heading (pose_heading),
        .goal_x       (goal_x_reg),
        .goal_y       (goal_y_reg),
        .lane_out     (front_lane),
        .lane_valid   (front_valid)
    );

    // Square root and CORDIC, side by side, one step per stage.
    gtg_iter u_iter (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_in   (front_lane),
        .valid_in  (front_valid),
        .lane_out  (iter_lane),
        .valid_out (iter_valid)
    );

    // Saturation, rounding and gains; registered outputs.
    gtg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .lane_in      (iter_lane),
        .valid_in     (iter_valid),
        .linear_gain  (lin_gain_reg),
        .angular_gain (ang_gain_reg),
        .done         (done),
        .linear_speed (linear_speed),
        .turn_rate    (turn_rate),
        .distance     (distance),
        .bearing      (bearing)
    );

    // Every accepted pose comes out after the fixed pipeline depth.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("pose beat did not produce a result at the expected latency");

    // A result never appears without a matching earlier accepted pose.
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result strobe without a matching pose beat");

    // Zero distance means the pose is on the goal, so bearing is zero.
    a_goal_bearing: assert property (@(posedge clk) disable iff (!rst_n)
        (done && distance == 16'd0) |-> (bearing == 15'sd0))
        else $error("nonzero bearing at zero distance");

    // Bearing is clamped to plus or minus pi.
    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (bearing <= BEARING_MAX && bearing >= BEARING_MIN))
        else $error("bearing outside plus or minus pi");

endmodule

`default_nettype wire
